### design/psi_pkg.sv
// ---------------------------------------------------------------------------
// psi_pkg
// Shared types, constants and helper functions of the stored-deflate PNG
// encoder: sequencer phases, chunk codes, CRC-32 byte step.
// ---------------------------------------------------------------------------
package psi_pkg;

    // default limits handed to the top level
    localparam int MAX_SIDE_DEF    = 4096;
    localparam int BLOCK_LIMIT_DEF = 65535;

    // widths of the internal counters
    localparam int SIDE_W = 13;
    localparam int COL_W  = 15;
    localparam int RAW_W  = 28;

    // register reset values
    localparam logic [SIDE_W-1:0] WIDTH_RST  = 13'd800;
    localparam logic [SIDE_W-1:0] HEIGHT_RST = 13'd600;

    // register indexes (paddr bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // checksum constants
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // chunk codes and fixed header bytes
    localparam logic [31:0] TYPE_IHDR = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT = 32'h49444154;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;
    localparam logic [31:0] IHDR_LEN  = 32'd13;
    localparam logic [7:0]  BIT_DEPTH = 8'd8;
    localparam logic [7:0]  COLOR_RGB = 8'd2;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;
    localparam logic [7:0]  FILTER_NONE = 8'h00;

    // byte sequencer phases
    typedef enum logic [4:0] {
        P_IDLE,
        P_SIG,
        P_IHDR_LEN,
        P_IHDR_TYPE,
        P_IHDR_DATA,
        P_IHDR_CRC,
        P_IDAT_LEN,
        P_IDAT_TYPE,
        P_ZLIB,
        P_BHDR,
        P_FILTER,
        P_PIXEL,
        P_ADLER,
        P_IDAT_CRC,
        P_IEND_LEN,
        P_IEND_TYPE,
        P_IEND_CRC
    } phase_t;

    // png signature bytes
    function automatic logic [7:0] sig_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // big-endian byte of a word
    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            2'd3:    b = w[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // reflected crc-32 over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/png_stored_image_encoder.sv
// ---------------------------------------------------------------------------
// png_stored_image_encoder
// Streams an 8-bit RGB image in as component bytes and a complete PNG file
// out as bytes: signature, IHDR, one IDAT of stored deflate blocks, IEND.
// ---------------------------------------------------------------------------
//
//  channel   | signals                                    | direction
//  ----------+--------------------------------------------+----------
//  config    | psel penable pwrite paddr pwdata prdata    | in / out
//  pixel     | in_valid in_stall pixel_byte               | in
//  png byte  | out_valid out_stall out_byte last_of_run   | out
//            | end_of_file                                |
//
//  One output byte per cycle from a byte sequencer into an output register.
//  A pixel request mid-row emits one byte; a row start adds the filter byte,
//  a stored block start adds 5 header bytes, the first pixel of a file adds
//  43 header bytes and the last pixel adds 20 trailer bytes.
//  The next request is taken in the cycle that the current one's last byte
//  enters the output register. A stall on the output holds the sequencer.
//  Reset is asynchronous, active low; no clearing pass.
//
module png_stored_image_encoder #(
    parameter int MAX_SIDE    = psi_pkg::MAX_SIDE_DEF,
    parameter int BLOCK_LIMIT = psi_pkg::BLOCK_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        end_of_file
);

    localparam int SIDE_W = psi_pkg::SIDE_W;
    localparam int COL_W  = psi_pkg::COL_W;
    localparam int RAW_W  = psi_pkg::RAW_W;
    localparam int SIDE_CAP = (MAX_SIDE > 8191) ? 8191 : MAX_SIDE;
    localparam logic [SIDE_W-1:0] CAP   = SIDE_W'(SIDE_CAP);
    localparam logic [15:0]       LIMIT = 16'(BLOCK_LIMIT);
    // exact reciprocal for the rounded-up block count
    localparam int BLK_N  = RAW_W + 1;
    localparam int BLK_L  = $clog2(BLOCK_LIMIT);
    localparam int BLK_S  = BLK_N + BLK_L;
    localparam int PROD_W = 2 * BLK_N + 1;
    localparam longint unsigned BLK_M =
        ((64'd1 << BLK_S) + 64'(BLOCK_LIMIT) - 64'd1) / 64'(BLOCK_LIMIT);

    // configuration registers
    logic [SIDE_W-1:0] width_reg, height_reg;
    // sequencer state
    psi_pkg::phase_t phase_reg, phase_next;
    logic [3:0]        idx_reg, idx_next;
    logic [7:0]        pix_reg, pix_next;
    logic              file_open_reg, file_open_next;
    logic              fd_reg, fd_next;
    logic [31:0]       crc_reg, crc_next;
    logic [15:0]       adler_lo_reg, adler_lo_next;
    logic [15:0]       adler_hi_reg, adler_hi_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SIDE_W-1:0] row_reg, row_next;
    logic [15:0]       bl_reg, bl_next;
    logic [RAW_W-1:0]  rl_reg, rl_next;
    logic [RAW_W-1:0]  raw_reg;
    // block count
    logic [BLK_N-1:0]  blk_num;
    logic [PROD_W-1:0] blk_prod;
    logic [RAW_W-1:0]  blocks_reg;
    logic              div_start;
    // output register
    logic              ov_reg, last_reg, eof_reg;
    logic [7:0]        ob_reg;

    logic              advance, accept;
    logic [7:0]        e_byte;
    logic              e_chk, e_last, e_eof;

    // clamped image size and file geometry
    logic [SIDE_W-1:0] w_use, h_use;
    logic [COL_W-1:0]  row_len;
    logic [RAW_W-1:0]  raw_calc;
    logic [RAW_W-1:0]  blocks;
    logic [31:0]       idat_len;
    logic [15:0]       blk_len;

    assign w_use = (width_reg == '0) ? SIDE_W'(1) : ((width_reg > CAP) ? CAP : width_reg);
    assign h_use = (height_reg == '0) ? SIDE_W'(1) : ((height_reg > CAP) ? CAP : height_reg);
    assign row_len  = COL_W'({w_use, 1'b0}) + COL_W'(w_use);
    assign raw_calc = RAW_W'((row_len + COL_W'(1)) * h_use);
    assign blk_num  = BLK_N'(raw_reg) + BLK_N'(BLOCK_LIMIT - 1);
    assign blk_prod = PROD_W'(blk_num) * PROD_W'(BLK_M);
    assign blocks   = RAW_W'(blk_prod >> BLK_S);
    assign idat_len = 32'(raw_reg) + 32'({blocks_reg, 2'b00}) + 32'(blocks_reg) + 32'd6;
    assign blk_len  = (rl_reg > RAW_W'(LIMIT)) ? LIMIT : rl_reg[15:0];

    // apb port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == psi_pkg::REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= psi_pkg::WIDTH_RST;
            height_reg <= psi_pkg::HEIGHT_RST;
        end
        else if (psel && penable && pwrite && !file_open_reg)
        begin
            if (paddr[2] == psi_pkg::REG_WIDTH)
            begin
                width_reg <= pwdata[SIDE_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[SIDE_W-1:0];
            end
        end
    end

    // next raw step: block header, filter byte or pixel byte
    function automatic psi_pkg::phase_t raw_phase(input logic [COL_W-1:0] col,
                                                  input logic fd, input logic [15:0] bl);
        psi_pkg::phase_t p;
        if (bl == '0)
        begin
            p = psi_pkg::P_BHDR;
        end
        else if (col == '0 && !fd)
        begin
            p = psi_pkg::P_FILTER;
        end
        else
        begin
            p = psi_pkg::P_PIXEL;
        end
        return p;
    endfunction

    assign advance  = !ov_reg || !out_stall;
    assign in_stall = (phase_reg != psi_pkg::P_IDLE) && !(advance && e_last);
    assign accept   = in_valid && !in_stall;

    // byte sequencer
    always_comb
    begin
        logic [31:0] crc_base;
        logic [16:0] lo_sum, hi_sum;
        logic [15:0] lo_new;
        logic [15:0] bl_dec;
        logic [COL_W-1:0] col_inc;
        logic [SIDE_W-1:0] row_inc;

        phase_next     = phase_reg;
        idx_next       = idx_reg;
        pix_next       = pix_reg;
        file_open_next = file_open_reg;
        fd_next        = fd_reg;
        crc_next       = crc_reg;
        adler_lo_next  = adler_lo_reg;
        adler_hi_next  = adler_hi_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        bl_next        = bl_reg;
        rl_next        = rl_reg;
        div_start      = 1'b0;
        e_byte = 8'h00;
        e_chk  = 1'b0;
        e_last = 1'b0;
        e_eof  = 1'b0;

        bl_dec  = (bl_reg != '0) ? bl_reg - 16'd1 : bl_reg;
        col_inc = col_reg + COL_W'(1);
        row_inc = row_reg + SIDE_W'(1);

        // byte for the current step
        case (phase_reg)
            psi_pkg::P_SIG:       e_byte = psi_pkg::sig_byte(idx_reg[2:0]);
            psi_pkg::P_IHDR_LEN:  e_byte = psi_pkg::be_byte(psi_pkg::IHDR_LEN, idx_reg[1:0]);
            psi_pkg::P_IHDR_TYPE:
            begin
                e_byte = psi_pkg::be_byte(psi_pkg::TYPE_IHDR, idx_reg[1:0]);
                e_chk  = 1'b1;
            end
            psi_pkg::P_IHDR_DATA:
            begin
                e_chk = 1'b1;
                if (idx_reg < 4'd4)
                begin
                    e_byte = psi_pkg::be_byte(32'(w_use), idx_reg[1:0]);
                end
                else if (idx_reg < 4'd8)
                begin
                    e_byte = psi_pkg::be_byte(32'(h_use), idx_reg[1:0]);
                end
                else if (idx_reg == 4'd8)
                begin
                    e_byte = psi_pkg::BIT_DEPTH;
                end
                else if (idx_reg == 4'd9)
                begin
                    e_byte = psi_pkg::COLOR_RGB;
                end
            end
            psi_pkg::P_IDAT_LEN:  e_byte = psi_pkg::be_byte(idat_len, idx_reg[1:0]);
            psi_pkg::P_IDAT_TYPE:
            begin
                e_byte = psi_pkg::be_byte(psi_pkg::TYPE_IDAT, idx_reg[1:0]);
                e_chk  = 1'b1;
            end
            psi_pkg::P_ZLIB:
            begin
                e_byte = (idx_reg == '0) ? psi_pkg::ZLIB_CMF : psi_pkg::ZLIB_FLG;
                e_chk  = 1'b1;
            end
            psi_pkg::P_BHDR:
            begin
                e_chk = 1'b1;
                case (idx_reg)
                    4'd0:    e_byte = {7'd0, rl_reg <= RAW_W'(LIMIT)};
                    4'd1:    e_byte = blk_len[7:0];
                    4'd2:    e_byte = blk_len[15:8];
                    4'd3:    e_byte = ~blk_len[7:0];
                    default: e_byte = ~blk_len[15:8];
                endcase
            end
            psi_pkg::P_FILTER:
            begin
                e_byte = psi_pkg::FILTER_NONE;
                e_chk  = 1'b1;
            end
            psi_pkg::P_PIXEL:
            begin
                e_byte = pix_reg;
                e_chk  = 1'b1;
            end
            psi_pkg::P_ADLER:
            begin
                e_byte = psi_pkg::be_byte({adler_hi_reg, adler_lo_reg}, idx_reg[1:0]);
                e_chk  = 1'b1;
            end
            psi_pkg::P_IHDR_CRC, psi_pkg::P_IDAT_CRC, psi_pkg::P_IEND_CRC:
                e_byte = psi_pkg::be_byte(~crc_reg, idx_reg[1:0]);
            psi_pkg::P_IEND_TYPE:
            begin
                e_byte = psi_pkg::be_byte(psi_pkg::TYPE_IEND, idx_reg[1:0]);
                e_chk  = 1'b1;
            end
            default: e_byte = 8'h00;
        endcase

        // running chunk crc, restarted at each chunk type
        crc_base = ((phase_reg == psi_pkg::P_IHDR_TYPE || phase_reg == psi_pkg::P_IDAT_TYPE ||
                     phase_reg == psi_pkg::P_IEND_TYPE) && idx_reg == '0)
                   ? psi_pkg::CRC_INIT : crc_reg;

        // adler sums over a raw byte
        lo_sum = 17'(adler_lo_reg) + 17'(e_byte);
        lo_new = (lo_sum >= psi_pkg::ADLER_MOD) ? 16'(lo_sum - psi_pkg::ADLER_MOD)
                                                 : lo_sum[15:0];
        hi_sum = 17'(adler_hi_reg) + 17'(lo_new);

        // state step for one emitted byte
        if (advance && phase_reg != psi_pkg::P_IDLE)
        begin
            if (e_chk)
            begin
                crc_next = psi_pkg::crc_byte(crc_base, e_byte);
            end
            idx_next = idx_reg + 4'd1;
            case (phase_reg)
                psi_pkg::P_SIG:
                    if (idx_reg == 4'd7)
                    begin
                        phase_next = psi_pkg::P_IHDR_LEN;
                        idx_next   = '0;
                    end
                psi_pkg::P_IHDR_LEN:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_IHDR_TYPE;
                        idx_next   = '0;
                    end
                psi_pkg::P_IHDR_TYPE:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_IHDR_DATA;
                        idx_next   = '0;
                    end
                psi_pkg::P_IHDR_DATA:
                    if (idx_reg == 4'd12)
                    begin
                        phase_next = psi_pkg::P_IHDR_CRC;
                        idx_next   = '0;
                    end
                psi_pkg::P_IHDR_CRC:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_IDAT_LEN;
                        idx_next   = '0;
                    end
                psi_pkg::P_IDAT_LEN:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_IDAT_TYPE;
                        idx_next   = '0;
                    end
                psi_pkg::P_IDAT_TYPE:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_ZLIB;
                        idx_next   = '0;
                    end
                psi_pkg::P_ZLIB:
                    if (idx_reg == 4'd1)
                    begin
                        phase_next = raw_phase(col_reg, fd_reg, bl_reg);
                        idx_next   = '0;
                    end
                psi_pkg::P_BHDR:
                    if (idx_reg == 4'd4)
                    begin
                        bl_next    = blk_len;
                        phase_next = raw_phase(col_reg, fd_reg, blk_len);
                        idx_next   = '0;
                    end
                psi_pkg::P_FILTER:
                begin
                    bl_next       = bl_dec;
                    rl_next       = (rl_reg != '0) ? rl_reg - RAW_W'(1) : rl_reg;
                    adler_lo_next = lo_new;
                    adler_hi_next = (hi_sum >= psi_pkg::ADLER_MOD)
                                    ? 16'(hi_sum - psi_pkg::ADLER_MOD) : hi_sum[15:0];
                    fd_next       = 1'b1;
                    phase_next    = raw_phase(col_reg, 1'b1, bl_dec);
                    idx_next      = '0;
                end
                psi_pkg::P_PIXEL:
                begin
                    bl_next       = bl_dec;
                    rl_next       = (rl_reg != '0) ? rl_reg - RAW_W'(1) : rl_reg;
                    adler_lo_next = lo_new;
                    adler_hi_next = (hi_sum >= psi_pkg::ADLER_MOD)
                                    ? 16'(hi_sum - psi_pkg::ADLER_MOD) : hi_sum[15:0];
                    fd_next       = 1'b0;
                    idx_next      = '0;
                    if (col_inc >= row_len)
                    begin
                        col_next = '0;
                        if (row_inc >= h_use)
                        begin
                            row_next   = '0;
                            rl_next    = '0;
                            bl_next    = '0;
                            phase_next = psi_pkg::P_ADLER;
                        end
                        else
                        begin
                            row_next   = row_inc;
                            phase_next = psi_pkg::P_IDLE;
                            e_last     = 1'b1;
                        end
                    end
                    else
                    begin
                        col_next   = col_inc;
                        phase_next = psi_pkg::P_IDLE;
                        e_last     = 1'b1;
                    end
                end
                psi_pkg::P_ADLER:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_IDAT_CRC;
                        idx_next   = '0;
                    end
                psi_pkg::P_IDAT_CRC:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_IEND_LEN;
                        idx_next   = '0;
                    end
                psi_pkg::P_IEND_LEN:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_IEND_TYPE;
                        idx_next   = '0;
                    end
                psi_pkg::P_IEND_TYPE:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next = psi_pkg::P_IEND_CRC;
                        idx_next   = '0;
                    end
                psi_pkg::P_IEND_CRC:
                    if (idx_reg == 4'd3)
                    begin
                        phase_next     = psi_pkg::P_IDLE;
                        idx_next       = '0;
                        e_last         = 1'b1;
                        e_eof          = 1'b1;
                        file_open_next = 1'b0;
                    end
                default: idx_next = '0;
            endcase
        end

        // new pixel request
        if (accept)
        begin
            pix_next = pixel_byte;
            idx_next = '0;
            if (!file_open_next)
            begin
                file_open_next = 1'b1;
                div_start      = 1'b1;
                rl_next        = raw_calc;
                bl_next        = '0;
                adler_lo_next  = 16'd1;
                adler_hi_next  = '0;
                col_next       = '0;
                row_next       = '0;
                fd_next        = 1'b0;
                phase_next     = psi_pkg::P_SIG;
            end
            else
            begin
                phase_next = raw_phase(col_next, fd_next, bl_next);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= psi_pkg::P_IDLE;
            idx_reg       <= '0;
            file_open_reg <= 1'b0;
            fd_reg        <= 1'b0;
            crc_reg       <= psi_pkg::CRC_INIT;
            adler_lo_reg  <= 16'd1;
            adler_hi_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            bl_reg        <= '0;
            rl_reg        <= '0;
            ov_reg        <= 1'b0;
            last_reg      <= 1'b0;
            eof_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            file_open_reg <= file_open_next;
            fd_reg        <= fd_next;
            crc_reg       <= crc_next;
            adler_lo_reg  <= adler_lo_next;
            adler_hi_reg  <= adler_hi_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            bl_reg        <= bl_next;
            rl_reg        <= rl_next;
            if (advance)
            begin
                ov_reg   <= (phase_reg != psi_pkg::P_IDLE);
                last_reg <= e_last;
                eof_reg  <= e_eof;
            end
        end
    end

    // payload: pixel, output byte, raw size, and the block count registered from the raw size
    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        if (advance)
        begin
            ob_reg <= e_byte;
        end
        if (div_start)
        begin
            raw_reg <= raw_calc;
        end
        blocks_reg <= blocks;
    end

    assign out_valid   = ov_reg;
    assign out_byte    = ob_reg;
    assign last_of_run = last_reg;
    assign end_of_file = eof_reg;

    // the file end is always the last byte of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_file |-> last_of_run)
        else $error("end_of_file without last_of_run");

    // the open block never runs past the rest of the raw data
    assert property (@(posedge clk) disable iff (!rst_n)
        bl_reg <= 16'(rl_reg) || rl_reg > RAW_W'(LIMIT))
        else $error("block count exceeds remaining raw bytes");

    // a closed file leaves the row position at its start
    assert property (@(posedge clk) disable iff (!rst_n)
        !file_open_reg |-> col_reg == '0 && row_reg == '0)
        else $error("row position not cleared with file closed");

endmodule

### test/png_stored_image_encoder_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// png_stored_image_encoder_check
// Watches the config port and both byte channels of the PNG encoder, builds
// the expected file bytes for every accepted pixel request and compares each
// accepted output byte against the oldest expected one.
// ---------------------------------------------------------------------------
module png_stored_image_encoder_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  pixel_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        last_of_run,
    input  logic        end_of_file,
    output int          fail_count,
    output int          png_pending,
    output int          files_done
);

    localparam int unsigned SIDE_MAX  = 4096;
    localparam int unsigned BLOCK_MAX = 65535;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
    } png_byte_t;

    png_byte_t png_queue[$];

    // predicted encoder state
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [31:0] crc_acc;
    int unsigned adler_a;
    int unsigned adler_b;
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned blk_left;
    int unsigned raw_todo;
    logic        in_file;

    function automatic int unsigned clamp_side(input logic [12:0] v);
        if (v == 0) return 1;
        if (v > SIDE_MAX) return SIDE_MAX;
        return v;
    endfunction

    task automatic emit_plain(input logic [7:0] b);
        png_queue.push_back('{data: b, last: 1'b0, eof: 1'b0});
    endtask

    // crc-32 step then emit
    task automatic emit_crc(input logic [7:0] b);
        logic [31:0] c;
        c = crc_acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? (psi_pkg::CRC_POLY ^ (c >> 1)) : (c >> 1);
        crc_acc = c;
        emit_plain(b);
    endtask

    task automatic emit_word(input logic [31:0] w, input logic with_crc);
        for (int s = 3; s >= 0; s--)
            if (with_crc) emit_crc(w[s*8 +: 8]);
            else emit_plain(w[s*8 +: 8]);
    endtask

    task automatic emit_type(input logic [31:0] t);
        crc_acc = psi_pkg::CRC_INIT;
        emit_word(t, 1'b1);
    endtask

    task automatic emit_chunk_crc();
        emit_word(crc_acc ^ psi_pkg::CRC_INIT, 1'b0);
    endtask

    // one zlib payload byte, with stored block header when one is due
    task automatic emit_raw(input logic [7:0] b);
        int unsigned len;
        logic [15:0] nlen;
        if (blk_left == 0) begin
            len = (raw_todo > BLOCK_MAX) ? BLOCK_MAX : raw_todo;
            nlen = ~len[15:0];
            emit_crc((raw_todo <= BLOCK_MAX) ? 8'd1 : 8'd0);
            emit_crc(len[7:0]);
            emit_crc(len[15:8]);
            emit_crc(nlen[7:0]);
            emit_crc(nlen[15:8]);
            blk_left = len;
        end
        emit_crc(b);
        if (blk_left != 0) blk_left--;
        if (raw_todo != 0) raw_todo--;
        adler_a += b;
        if (adler_a >= psi_pkg::ADLER_MOD) adler_a -= psi_pkg::ADLER_MOD;
        adler_b += adler_a;
        if (adler_b >= psi_pkg::ADLER_MOD) adler_b -= psi_pkg::ADLER_MOD;
    endtask

    // signature, IHDR and the IDAT head
    task automatic open_png();
        int unsigned w;
        int unsigned h;
        longint unsigned raw;
        longint unsigned nblk;
        longint unsigned idat_len;
        w = clamp_side(cfg_width);
        h = clamp_side(cfg_height);
        raw = (3 * w + 1) * h;
        nblk = (raw + BLOCK_MAX - 1) / BLOCK_MAX;
        idat_len = raw + 5 * nblk + 6;
        emit_word(32'h89504E47, 1'b0);
        emit_word(32'h0D0A1A0A, 1'b0);
        emit_word(psi_pkg::IHDR_LEN, 1'b0);
        emit_type(psi_pkg::TYPE_IHDR);
        emit_word(w, 1'b1);
        emit_word(h, 1'b1);
        emit_crc(psi_pkg::BIT_DEPTH);
        emit_crc(psi_pkg::COLOR_RGB);
        emit_crc(8'd0);
        emit_crc(8'd0);
        emit_crc(8'd0);
        emit_chunk_crc();
        emit_word(idat_len[31:0], 1'b0);
        emit_type(psi_pkg::TYPE_IDAT);
        emit_crc(psi_pkg::ZLIB_CMF);
        emit_crc(psi_pkg::ZLIB_FLG);
        raw_todo = raw[31:0];
        blk_left = 0;
        adler_a = 1;
        adler_b = 0;
        col_cnt = 0;
        row_cnt = 0;
        in_file = 1'b1;
    endtask

    // expected bytes for one pixel request
    task automatic predict_pixel(input logic [7:0] b);
        int unsigned w;
        int unsigned h;
        if (!in_file) open_png();
        w = clamp_side(cfg_width);
        h = clamp_side(cfg_height);
        if (col_cnt == 0) emit_raw(psi_pkg::FILTER_NONE);
        emit_raw(b);
        col_cnt++;
        if (col_cnt >= 3 * w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) begin
                emit_word({adler_b[15:0], adler_a[15:0]}, 1'b1);
                emit_chunk_crc();
                emit_word(32'd0, 1'b0);
                emit_type(psi_pkg::TYPE_IEND);
                emit_chunk_crc();
                png_queue[png_queue.size()-1].eof = 1'b1;
                in_file = 1'b0;
                row_cnt = 0;
                raw_todo = 0;
                blk_left = 0;
            end
        end
        png_queue[png_queue.size()-1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        png_pending = 0;
        files_done = 0;
        cfg_width = psi_pkg::WIDTH_RST;
        cfg_height = psi_pkg::HEIGHT_RST;
        crc_acc = psi_pkg::CRC_INIT;
        adler_a = 1;
        adler_b = 0;
        col_cnt = 0;
        row_cnt = 0;
        blk_left = 0;
        raw_todo = 0;
        in_file = 1'b0;
    end

    // config writes, pixel requests, output bytes
    always @(posedge clk)
    begin
        png_byte_t exp_byte;
        if (rst_n) begin
            if (psel && penable && pwrite && pready && !in_file) begin
                if (paddr[2] == psi_pkg::REG_WIDTH) cfg_width = pwdata[12:0];
                else cfg_height = pwdata[12:0];
            end
            if (in_valid && !in_stall)
                predict_pixel(pixel_byte);
            if (out_valid && !out_stall) begin
                if (png_queue.size() == 0) begin
                    report_mismatch("unexpected byte", 0, out_byte);
                end else begin
                    exp_byte = png_queue.pop_front();
                    if (out_byte !== exp_byte.data)
                        report_mismatch("out_byte", exp_byte.data, out_byte);
                    if (last_of_run !== exp_byte.last)
                        report_mismatch("last_of_run", exp_byte.last, last_of_run);
                    if (end_of_file !== exp_byte.eof)
                        report_mismatch("end_of_file", exp_byte.eof, end_of_file);
                    if (exp_byte.eof) files_done++;
                end
            end
            png_pending = png_queue.size();
        end
    end

endmodule

### test/png_stored_image_encoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// png_stored_image_encoder_test
// Drives small images through the PNG encoder (zero-size clamps, the
// smallest image, many small random images) under several idle and stall
// mixes; a checker module predicts and compares every byte.
// ---------------------------------------------------------------------------
module png_stored_image_encoder_test;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  pixel_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        end_of_file;

    int fail_count;
    int png_pending;
    int files_done;
    int cycle_cnt;
    int sender_idle_pct;
    int recv_stall_pct;
    int pixels_sent;

    png_stored_image_encoder dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .pixel_byte(pixel_byte),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .last_of_run(last_of_run), .end_of_file(end_of_file)
    );

    png_stored_image_encoder_check checker_inst (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_stall(in_stall), .pixel_byte(pixel_byte),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .last_of_run(last_of_run), .end_of_file(end_of_file),
        .fail_count(fail_count), .png_pending(png_pending), .files_done(files_done)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic reg_write(input logic reg_idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        pixels_sent++;
    endtask

    // wait for the encoder to drain before touching config
    task automatic drain();
        in_valid <= 1'b0;
        while (png_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // idle mix chosen per image
    task automatic set_mix(input int sel);
        case (sel % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    // one whole image; pattern 0 random, 1 extremes, 2 walking bits
    task automatic send_image(input logic [31:0] w, input logic [31:0] h,
                              input int pattern, input int sel, input logic do_cfg);
        int unsigned n;
        int unsigned wc;
        int unsigned hc;
        logic [7:0] b;
        drain();
        set_mix(sel);
        if (do_cfg) begin
            reg_write(psi_pkg::REG_WIDTH, w);
            reg_write(psi_pkg::REG_HEIGHT, h);
        end
        wc = (w[12:0] == 0) ? 1 : ((w[12:0] > 4096) ? 4096 : w[12:0]);
        hc = (h[12:0] == 0) ? 1 : ((h[12:0] > 4096) ? 4096 : h[12:0]);
        n = 3 * wc * hc;
        for (int unsigned i = 0; i < n; i++) begin
            case (pattern)
                1: b = (i % 2) ? 8'hFF : 8'h00;
                2: b = 8'h01 << (i % 8);
                default: b = 8'($urandom_range(255));
            endcase
            send_pixel(b);
        end
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        pixel_byte = '0;
        out_stall = 1'b0;
        cycle_cnt = 0;
        pixels_sent = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed sizes: smallest, zero clamps, a repeat without config
        send_image(1, 1, 1, 0, 1'b1);
        send_image(0, 0, 2, 1, 1'b1);
        send_image(2, 2, 1, 2, 1'b1);
        send_image(2, 2, 2, 3, 1'b0);
        send_image(3, 0, 0, 0, 1'b1);

        // random small images, sometimes back to back without a config write
        k = 0;
        while (k < 23) begin
            send_image($urandom_range(1, 3), $urandom_range(1, 3), 0, k,
                       ($urandom_range(3) != 0));
            k++;
        end

        drain();
        repeat (30) @(negedge clk);
        $display("covered %0d images and %0d pixel bytes, sizes from 1x1 to 3x3",
                 files_done, pixels_sent);
        $display("zero-size clamps and four idle/stall mixes included");
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
design/psi_pkg.sv
design/png_stored_image_encoder.sv
test/png_stored_image_encoder_check.sv
test/png_stored_image_encoder_test.sv
